FILE: rtl/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// shared types, codes and helpers of the block bitmap allocator
// ----------------------------------------------------------------------------
package bba_pkg;

	localparam int MAP_BYTES_DEF = 128;
	localparam int BLK_W = 11;
	localparam int GRANT_W = 11;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE = 1'b1;

	localparam logic [7:0] BYTE_FULL = 8'hff;
	localparam logic [7:0] BIT_ONE = 8'h01;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_FULL = 2'd1,
		ST_ZERO = 2'd2,
		ST_DOUBLE = 2'd3
	} status_t;

	typedef struct packed {
		logic req_type;
		logic [BLK_W-1:0] block_number;
	} req_t;

	typedef struct packed {
		logic [GRANT_W-1:0] granted_block;
		status_t status;
	} rsp_t;

	// position of the lowest clear bit
	function automatic logic [2:0] first_zero(input logic [7:0] v);
		logic [2:0] pos;
		pos = 3'd0;
		for (int i = 7; i >= 0; i--) begin
			if (!v[i]) begin
				pos = 3'(i);
			end
		end
		return pos;
	endfunction

endpackage

FILE: rtl/bba_ram.sv
// ----------------------------------------------------------------------------
// bba_ram
// bitmap storage, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module bba_ram #(
	parameter int DEPTH = bba_pkg::MAP_BYTES_DEF,
	parameter int AW = 7
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

FILE: rtl/block_bitmap_allocator_unit.sv
// ----------------------------------------------------------------------------
// block_bitmap_allocator_unit
// first-fit block allocator over a use bitmap held in a byte memory
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  req     | req_valid / req_ready  | req_type, block_number
//  rsp     | rsp_valid / rsp_ready  | granted_block, status
//
// allocate: the byte scan reads one memory word a cycle through the single read
//   port, from byte 0 up to the first byte with a clear bit, or over all
//   MAP_BYTES bytes when the map is full
// free: read, test, write back
// req_ready rises again in the same cycle as rsp_valid for the response
// after reset a clearing pass writes zero to all MAP_BYTES bytes before req_ready rises
// a finished response waits in the output register; a stalled rsp_ready holds
//   the next request in its last state until the register frees
// ----------------------------------------------------------------------------
module block_bitmap_allocator_unit #(
	parameter int MAP_BYTES = bba_pkg::MAP_BYTES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  bba_pkg::req_t  req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output bba_pkg::rsp_t  rsp
);

	localparam int AW = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
	localparam int CW = $clog2(MAP_BYTES + 1);
	localparam int ZW = (AW > 8) ? AW : 8;
	localparam int SW = AW + 4;
	localparam int GW = (SW > bba_pkg::GRANT_W) ? SW : bba_pkg::GRANT_W;

	typedef enum logic [5:0] {
		S_CLEAR   = 6'b000001,
		S_IDLE    = 6'b000010,
		S_FREE_RD = 6'b000100,
		S_FREE_CK = 6'b001000,
		S_SCAN    = 6'b010000,
		S_FINISH  = 6'b100000
	} state_t;

	state_t state_q;

	logic [AW-1:0] clr_q;
	logic [CW-1:0] scan_q;
	logic          pend_q;
	logic [AW-1:0] pend_addr_q;
	logic          zero_q;
	logic          range_q;
	logic [AW-1:0] free_addr_q;
	logic [2:0]    free_bit_q;

	logic          wr_en_q;
	logic [AW-1:0] wr_addr_q;
	logic [7:0]    wr_data_q;
	bba_pkg::rsp_t res_q;

	logic          rsp_valid_q;
	bba_pkg::rsp_t rsp_q;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [7:0]    ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [7:0]    rd_data;

	logic                out_free;
	logic                issue;
	logic                byte_full;
	logic [2:0]          hit_bit;
	logic [SW-1:0]       grant_sum;
	logic [GW-1:0]       grant_ext;
	logic [bba_pkg::BLK_W-1:0] blk_m1;
	logic [7:0]          free_byte;
	logic [ZW-1:0]       free_byte_ext;
	logic [7:0]          free_mask;

	assign out_free = !rsp_valid_q || rsp_ready;
	assign issue = scan_q < CW'(MAP_BYTES);
	assign byte_full = rd_data == bba_pkg::BYTE_FULL;
	assign hit_bit = bba_pkg::first_zero(rd_data);
	assign grant_sum = {1'b0, pend_addr_q, hit_bit} + SW'(1);
	assign grant_ext = GW'(grant_sum);
	assign blk_m1 = req.block_number - bba_pkg::BLK_W'(1);
	assign free_byte = blk_m1[bba_pkg::BLK_W-1:3];
	assign free_byte_ext = ZW'(free_byte);
	assign free_mask = bba_pkg::BIT_ONE << free_bit_q;

	// memory port selection
	always_comb begin
		ram_we = 1'b0;
		ram_waddr = wr_addr_q;
		ram_wdata = wr_data_q;
		ram_raddr = free_addr_q;
		unique case (state_q)
			S_CLEAR: begin
				ram_we = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = 8'h00;
			end
			S_SCAN: begin
				ram_raddr = scan_q[AW-1:0];
			end
			S_FINISH: begin
				ram_we = wr_en_q && out_free;
			end
			S_IDLE, S_FREE_RD, S_FREE_CK: begin
				ram_raddr = free_addr_q;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	bba_ram #(
		.DEPTH(MAP_BYTES),
		.AW(AW)
	) u_ram (
		.clk(clk),
		.wr_en(ram_we),
		.wr_addr(ram_waddr),
		.wr_data(ram_wdata),
		.rd_addr(ram_raddr),
		.rd_data(rd_data)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			scan_q <= '0;
			pend_q <= 1'b0;
			wr_en_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(MAP_BYTES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						if (req.req_type == bba_pkg::REQ_ALLOC) begin
							scan_q <= '0;
							pend_q <= 1'b0;
							state_q <= S_SCAN;
						end else begin
							state_q <= S_FREE_RD;
						end
					end
				end
				S_FREE_RD: begin
					state_q <= S_FREE_CK;
				end
				S_FREE_CK: begin
					wr_en_q <= !zero_q && !range_q && ((rd_data & free_mask) != 8'h00);
					state_q <= S_FINISH;
				end
				S_SCAN: begin
					if (pend_q && !byte_full) begin
						wr_en_q <= 1'b1;
						state_q <= S_FINISH;
					end else if (!issue) begin
						wr_en_q <= 1'b0;
						state_q <= S_FINISH;
					end else begin
						scan_q <= scan_q + CW'(1);
						pend_q <= 1'b1;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						wr_en_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request decode and result capture
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_valid) begin
			zero_q <= req.block_number == '0;
			range_q <= 32'(free_byte) >= MAP_BYTES;
			free_addr_q <= free_byte_ext[AW-1:0];
			free_bit_q <= blk_m1[2:0];
		end
		if (state_q == S_SCAN) begin
			pend_addr_q <= scan_q[AW-1:0];
			if (pend_q && !byte_full) begin
				wr_addr_q <= pend_addr_q;
				wr_data_q <= rd_data | (bba_pkg::BIT_ONE << hit_bit);
				res_q.granted_block <= grant_ext[bba_pkg::GRANT_W-1:0];
				res_q.status <= bba_pkg::ST_OK;
			end else begin
				res_q.granted_block <= '0;
				res_q.status <= bba_pkg::ST_FULL;
			end
		end
		if (state_q == S_FREE_CK) begin
			wr_addr_q <= free_addr_q;
			wr_data_q <= rd_data & ~free_mask;
			res_q.granted_block <= '0;
			if (zero_q) begin
				res_q.status <= bba_pkg::ST_ZERO;
			end else if (range_q || ((rd_data & free_mask) == 8'h00)) begin
				res_q.status <= bba_pkg::ST_DOUBLE;
			end else begin
				res_q.status <= bba_pkg::ST_OK;
			end
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == S_FINISH && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FINISH && out_free) begin
			rsp_q <= res_q;
		end
	end

	assign req_ready = state_q == S_IDLE;
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while a request is in progress");

	a_finish_pushes: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FINISH && out_free |=> rsp_valid)
		else $error("finished request did not reach the response register");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> scan_q <= CW'(MAP_BYTES))
		else $error("scan ran past the bitmap");

	a_grant_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != bba_pkg::ST_OK |-> rsp.granted_block == '0)
		else $error("block granted with an error status");

endmodule

FILE: dv/bba_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bba_checker
// Watches both channels of the block bitmap allocator. On each accepted
// request it updates its own copy of the use bitmap. From that copy it
// predicts the response: the first-fit grant, a full map, a free of block
// zero, or a double free. Each accepted response is compared field by field
// with the oldest prediction. It counts failures and reports how many
// predicted responses are still waiting.
// ----------------------------------------------------------------------------
module bba_checker #(
	parameter int MAP_BYTES = bba_pkg::MAP_BYTES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  logic           req_ready,
	input  bba_pkg::req_t  req,
	input  logic           rsp_valid,
	input  logic           rsp_ready,
	input  bba_pkg::rsp_t  rsp,
	output int             fail_count,
	output int             pending,
	output int             req_count,
	output int             grant_count,
	output int             full_count,
	output int             zero_count,
	output int             double_count
);

	logic [7:0] use_map [MAP_BYTES];
	bba_pkg::rsp_t due_rsp [$];
	bba_pkg::rsp_t want;

	function automatic bba_pkg::rsp_t grant_or_release(input bba_pkg::req_t r);
		bba_pkg::rsp_t res;
		logic [bba_pkg::BLK_W-1:0] idx;
		res.granted_block = '0;
		res.status = bba_pkg::ST_FULL;
		if (r.req_type == bba_pkg::REQ_ALLOC) begin
			for (int i = 0; i < MAP_BYTES; i++) begin
				if (res.status == bba_pkg::ST_FULL && use_map[i] != bba_pkg::BYTE_FULL) begin
					for (int b = 0; b < 8; b++) begin
						if (res.status == bba_pkg::ST_FULL && !use_map[i][b]) begin
							use_map[i][b] = 1'b1;
							res.granted_block = bba_pkg::GRANT_W'(i * 8 + b + 1);
							res.status = bba_pkg::ST_OK;
						end
					end
				end
			end
		end else if (r.block_number == '0) begin
			res.status = bba_pkg::ST_ZERO;
		end else begin
			idx = r.block_number - 1'b1;
			if (int'(idx) >= MAP_BYTES * 8 || !use_map[idx >> 3][idx[2:0]]) begin
				res.status = bba_pkg::ST_DOUBLE;
			end else begin
				use_map[idx >> 3][idx[2:0]] = 1'b0;
				res.status = bba_pkg::ST_OK;
			end
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAP_BYTES; i++) begin
				use_map[i] = '0;
			end
			due_rsp.delete();
			fail_count = 0;
			pending = 0;
			req_count = 0;
			grant_count = 0;
			full_count = 0;
			zero_count = 0;
			double_count = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (due_rsp.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("%0t: unexpected response grant=%0d status=%0d",
							$realtime, rsp.granted_block, rsp.status);
					end
				end else begin
					want = due_rsp.pop_front();
					if (rsp.granted_block !== want.granted_block ||
						rsp.status !== want.status) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("%0t: mismatch grant exp=%0d act=%0d status exp=%0d act=%0d",
								$realtime, want.granted_block, rsp.granted_block,
								want.status, rsp.status);
						end
					end
				end
			end
			if (req_valid && req_ready) begin
				want = grant_or_release(req);
				due_rsp.push_back(want);
				req_count++;
				case (want.status)
					bba_pkg::ST_OK: begin
						if (req.req_type == bba_pkg::REQ_ALLOC) begin
							grant_count++;
						end
					end
					bba_pkg::ST_FULL: begin
						full_count++;
					end
					bba_pkg::ST_ZERO: begin
						zero_count++;
					end
					default: begin
						double_count++;
					end
				endcase
			end
			pending = due_rsp.size();
		end
	end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the block bitmap allocator. A short directed
// sequence covers first-fit reuse, double frees, block zero and blocks past
// the map. Random traffic follows. It first fills the map until allocations
// report it full, then mixes allocations and frees. Both sides idle at
// random, and a checker beside the block does all prediction and
// comparison.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int MAP_BLOCKS = bba_pkg::MAP_BYTES_DEF * 8;
	localparam int BLK_MAX = (1 << bba_pkg::BLK_W) - 1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	bba_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	bba_pkg::rsp_t rsp;

	int fail_count;
	int pending;
	int req_count;
	int grant_count;
	int full_count;
	int zero_count;
	int double_count;
	bit steady = 1'b0;

	block_bitmap_allocator_unit #(
		.MAP_BYTES(bba_pkg::MAP_BYTES_DEF)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	bba_checker #(
		.MAP_BYTES(bba_pkg::MAP_BYTES_DEF)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.fail_count(fail_count),
		.pending(pending),
		.req_count(req_count),
		.grant_count(grant_count),
		.full_count(full_count),
		.zero_count(zero_count),
		.double_count(double_count)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int idle_len();
		int pick;
		pick = $urandom_range(0, 99);
		if (steady || pick < 60) begin
			return 0;
		end else if (pick < 90) begin
			return $urandom_range(1, 3);
		end else if (pick < 96) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(30, 150);
	endfunction

	task automatic send_req(input logic kind, input logic [bba_pkg::BLK_W-1:0] blk);
		int gap;
		req_valid <= 1'b1;
		req <= '{req_type: kind, block_number: blk};
		@(posedge clk);
		while (!req_ready) begin
			@(posedge clk);
		end
		gap = idle_len();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	initial begin : rsp_drain
		int n;
		wait (arst_n);
		forever begin
			rsp_ready <= 1'b1;
			repeat ($urandom_range(1, 40)) @(posedge clk);
			n = idle_len();
			if (n > 0) begin
				rsp_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
		end
	end

	initial begin
		#30_000_000;
		$display("tb: failure");
		$finish;
	end

	initial begin : stim
		int pick;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// first fit reuse, double free, block zero, past the map
		send_req(bba_pkg::REQ_ALLOC, '0);
		send_req(bba_pkg::REQ_ALLOC, '0);
		send_req(bba_pkg::REQ_ALLOC, '0);
		send_req(bba_pkg::REQ_FREE, bba_pkg::BLK_W'(2));
		send_req(bba_pkg::REQ_ALLOC, '0);
		send_req(bba_pkg::REQ_FREE, bba_pkg::BLK_W'(2));
		send_req(bba_pkg::REQ_FREE, bba_pkg::BLK_W'(2));
		send_req(bba_pkg::REQ_FREE, '0);
		send_req(bba_pkg::REQ_FREE, bba_pkg::BLK_W'(BLK_MAX));
		send_req(bba_pkg::REQ_FREE, bba_pkg::BLK_W'(MAP_BLOCKS + 1));
		send_req(bba_pkg::REQ_FREE, bba_pkg::BLK_W'(MAP_BLOCKS));
		send_req(bba_pkg::REQ_FREE, bba_pkg::BLK_W'(1));
		send_req(bba_pkg::REQ_FREE, bba_pkg::BLK_W'(3));
		send_req(bba_pkg::REQ_ALLOC, bba_pkg::BLK_W'(BLK_MAX));
		send_req(bba_pkg::REQ_ALLOC, bba_pkg::BLK_W'(MAP_BLOCKS));

		// fill the map until allocations come back full
		for (int i = 0; i < 1200; i++) begin
			if (i % 50 == 0) begin
				steady = ($urandom_range(0, 3) == 0);
			end
			if ($urandom_range(0, 99) < 96) begin
				send_req(bba_pkg::REQ_ALLOC, bba_pkg::BLK_W'($urandom));
			end else begin
				send_req(bba_pkg::REQ_FREE, bba_pkg::BLK_W'($urandom_range(0, BLK_MAX)));
			end
		end

		// last block on a full map
		send_req(bba_pkg::REQ_FREE, bba_pkg::BLK_W'(MAP_BLOCKS));
		send_req(bba_pkg::REQ_ALLOC, '0);
		send_req(bba_pkg::REQ_ALLOC, '0);
		send_req(bba_pkg::REQ_FREE, bba_pkg::BLK_W'(1));
		send_req(bba_pkg::REQ_ALLOC, '0);

		// churn: holes opened and refilled first fit
		for (int i = 0; i < 500; i++) begin
			if (i % 50 == 0) begin
				steady = ($urandom_range(0, 3) == 0);
			end
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				send_req(bba_pkg::REQ_ALLOC, bba_pkg::BLK_W'($urandom));
			end else if (pick < 90) begin
				send_req(bba_pkg::REQ_FREE, bba_pkg::BLK_W'($urandom_range(1, MAP_BLOCKS)));
			end else begin
				send_req(bba_pkg::REQ_FREE, bba_pkg::BLK_W'($urandom_range(0, BLK_MAX)));
			end
		end
		req_valid <= 1'b0;

		// let the checker log the last request before waiting on it
		@(posedge clk);
		wait (pending == 0);
		repeat (2 * bba_pkg::MAP_BYTES_DEF + 16) @(posedge clk);

		$display("tb: %0d requests, %0d grants, %0d map full, %0d block zero, %0d double frees",
			req_count, grant_count, full_count, zero_count, double_count);
		if (fail_count == 0 && pending == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: %0d failures, %0d responses missing", fail_count, pending);
			$display("tb: failure");
		end
		$finish;
	end

endmodule
